// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the RTL of the color vote block.
// Depends on nothing; included by modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define HWCV_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define HWCV_NEVER(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) else $error(msg);
`else
`define HWCV_ASSERT(label, clk, rst_n, prop, msg)
`define HWCV_NEVER(label, clk, rst_n, prop, msg)
`endif
`endif

// ===== rtl/core/hwcv_pkg.sv =====
// Package of the color vote block: constants, types, classifier and paint table.
// Depends on nothing.
`timescale 1ns / 1ps
package hwcv_pkg;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;
    localparam int MAX_WINDOW_DEF = 10;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;
    localparam int VOTE_W     = 9;
    localparam int NUM_CLASS  = 7;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WHITE_HIGH   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WHITE_LOW    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ROOM_ENABLE  = 3'd5;

    localparam logic [2:0] CLASS_PINK      = 3'd0;
    localparam logic [2:0] CLASS_BLUE      = 3'd1;
    localparam logic [2:0] CLASS_GREEN     = 3'd2;
    localparam logic [2:0] CLASS_YELLOW    = 3'd3;
    localparam logic [2:0] CLASS_ORANGE    = 3'd4;
    localparam logic [2:0] CLASS_RED       = 3'd5;
    localparam logic [2:0] CLASS_WHITE     = 3'd6;
    localparam logic [2:0] CLASS_UNPAINTED = 3'd7;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DECIDE
    } state_t;

    typedef struct packed {
        logic clear;
        logic add;
    } cell_ctrl_t;

    function automatic logic [VOTE_W-1:0] classify(
        input logic [7:0] h,
        input logic [7:0] s,
        input logic [7:0] v,
        input logic [7:0] white_high,
        input logic [7:0] white_low,
        input logic       room_en
    );
        logic [5:0] bits;
        logic [2:0] white;
        bits = '0;
        white = '0;
        bits[0] = (h > 8'd164) && (h < 8'd178) && (s >= 8'd125) && (v >= 8'd50) && (v <= 8'd220);
        bits[1] = (h > 8'd100) && (h < 8'd140) && (s >= 8'd95) && (v >= 8'd5) && (v <= 8'd95);
        bits[2] = (h > 8'd40) && (h < 8'd80) && (s >= 8'd45) && (s <= 8'd225) && (v <= 8'd70);
        bits[3] = (h > 8'd20) && (h < 8'd40) && (s >= 8'd150) && (v >= 8'd80);
        bits[4] = (h > 8'd2) && (h < 8'd19) && (s >= 8'd180) && (v >= 8'd100);
        bits[5] = ((h < 8'd3) || (h > 8'd175)) && (s >= 8'd140) && (v >= 8'd35) && (v <= 8'd90);
        if (v >= white_high)
        begin
            white = white + 3'd1;
        end
        if (v <= white_low)
        begin
            white = white + 3'd1;
        end
        if (room_en && (h >= 8'd7) && (h <= 8'd25) && (s >= 8'd43) && (s <= 8'd94)
            && (v <= 8'd193))
        begin
            white = white + 3'd2;
        end
        return {white, bits};
    endfunction

    function automatic logic [23:0] paint_bgr(input logic [2:0] cls);
        logic [23:0] p;
        unique case (cls)
            CLASS_PINK:   p = {8'd67, 8'd8, 8'd246};
            CLASS_BLUE:   p = {8'd255, 8'd1, 8'd61};
            CLASS_GREEN:  p = {8'd57, 8'd255, 8'd0};
            CLASS_YELLOW: p = {8'd13, 8'd191, 8'd255};
            CLASS_ORANGE: p = {8'd7, 8'd71, 8'd255};
            CLASS_RED:    p = {8'd0, 8'd7, 8'd245};
            default:      p = 24'd0;
        endcase
        return p;
    endfunction

endpackage

// ===== rtl/core/hwcv_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps
module hwcv_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/hwcv_cell.sv =====
// One vote cell: holds the window sum of one class and passes the running
// first-largest class on to its neighbor. Depends on hwcv_pkg.
`timescale 1ns / 1ps
module hwcv_cell #(
    parameter int         SUM_W    = 9,
    parameter logic [2:0] CLASS_ID = 3'd0
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  hwcv_pkg::cell_ctrl_t ctrl,
    input  logic [2:0]           amount,
    input  logic [SUM_W-1:0]     in_best,
    input  logic [2:0]           in_idx,
    input  logic                 in_any,
    output logic [SUM_W-1:0]     out_best,
    output logic [2:0]           out_idx,
    output logic                 out_any
);

    logic [SUM_W-1:0] sum_reg;
    logic [SUM_W-1:0] sum_next;

    always_comb
    begin
        sum_next = sum_reg;
        if (ctrl.clear)
        begin
            sum_next = '0;
        end
        else if (ctrl.add)
        begin
            sum_next = sum_reg + SUM_W'(amount);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
        end
        else
        begin
            sum_reg <= sum_next;
        end
    end

    assign out_best = (sum_reg > in_best) ? sum_reg : in_best;
    assign out_idx  = (sum_reg > in_best) ? CLASS_ID : in_idx;
    assign out_any  = in_any | (sum_reg != '0);

endmodule

// ===== rtl/core/hsv_window_color_vote_unit.sv =====
// Top level of the HSV window color vote block: position tracking, vote line
// store, window scan and the chain of vote cells. Depends on hwcv_pkg,
// hwcv_ram, hwcv_cell and assert_macros.svh.
//
//   Channel   Signals                                   Direction
//   pixel     in_valid/in_ready, hue, saturation,       in
//             brightness
//   result    out_valid/out_ready, class_index,         out
//             paint_blue, paint_green, paint_red
//   config    cfg_we, cfg_index, cfg_data               in
//
// A pixel with an active window passes through the scan, drain and decide states;
// others go straight to decide; the scan reads one line store entry per cycle.
// Reset clears the position counters and the controller; the store is not cleared.
// A stalled result holds in the output register; the next pixel is taken meanwhile.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module hsv_window_color_vote_unit #(
    parameter int MAX_WIDTH  = hwcv_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = hwcv_pkg::MAX_HEIGHT_DEF,
    parameter int MAX_WINDOW = hwcv_pkg::MAX_WINDOW_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [hwcv_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [hwcv_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [7:0]                      hue,
    input  logic [7:0]                      saturation,
    input  logic [7:0]                      brightness,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [2:0]                      class_index,
    output logic [7:0]                      paint_blue,
    output logic [7:0]                      paint_green,
    output logic [7:0]                      paint_red
);

    localparam int CW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int RW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int SW    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int WNW   = $clog2(MAX_WINDOW + 1) > 4 ? $clog2(MAX_WINDOW + 1) : 4;
    localparam int DEPTH = MAX_WINDOW * MAX_WIDTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int SUM_W = $clog2(MAX_WINDOW * MAX_WINDOW * 4 + 1);
    localparam int NC    = hwcv_pkg::NUM_CLASS;

    logic [10:0] frame_width_reg;
    logic [10:0] frame_height_reg;
    logic [3:0]  window_size_reg;
    logic [7:0]  white_high_reg;
    logic [7:0]  white_low_reg;
    logic        room_enable_reg;

    hwcv_pkg::state_t state_reg;
    hwcv_pkg::state_t state_next;

    logic [CW-1:0]  col_reg;
    logic [RW-1:0]  row_reg;
    logic [SW-1:0]  slot_reg;
    logic [CW-1:0]  base_col_reg;
    logic [CW-1:0]  rd_col_reg;
    logic [SW-1:0]  rd_slot_reg;
    logic [WNW-1:0] cnt_i_reg;
    logic [WNW-1:0] cnt_j_reg;
    logic [WNW-1:0] win_reg;
    logic           active_reg;
    logic           rd_pending_reg;
    logic           out_valid_reg;
    logic [2:0]     class_reg;
    logic [23:0]    paint_reg;

    logic           in_xfer;
    logic           scan_last;
    logic           row_last;
    logic           load_out;
    logic [CW:0]    width_eff;
    logic [RW:0]    height_eff;
    logic [WNW-1:0] win_eff;
    logic           active_now;
    logic [CW:0]    col_inc;
    logic [RW:0]    row_inc;
    logic [AW-1:0]  waddr;
    logic [AW-1:0]  raddr;
    logic [hwcv_pkg::VOTE_W-1:0] vote;
    logic [hwcv_pkg::VOTE_W-1:0] rdata;
    logic [2:0]     final_class;
    logic           scan_or_drain;
    logic           bad_paint;

    hwcv_pkg::cell_ctrl_t ctrl;
    logic [SUM_W-1:0] link_best [NC+1];
    logic [2:0]       link_idx  [NC+1];
    logic             link_any  [NC+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= 11'd640;
            frame_height_reg <= 11'd360;
            window_size_reg  <= 4'd1;
            white_high_reg   <= 8'd255;
            white_low_reg    <= 8'd0;
            room_enable_reg  <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                hwcv_pkg::REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data;
                hwcv_pkg::REG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                hwcv_pkg::REG_WINDOW_SIZE:  window_size_reg  <= cfg_data[3:0];
                hwcv_pkg::REG_WHITE_HIGH:   white_high_reg   <= cfg_data[7:0];
                hwcv_pkg::REG_WHITE_LOW:    white_low_reg    <= cfg_data[7:0];
                hwcv_pkg::REG_ROOM_ENABLE:  room_enable_reg  <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        if (frame_width_reg == 11'd0)
        begin
            width_eff = (CW+1)'(1);
        end
        else if (32'(frame_width_reg) > 32'(MAX_WIDTH))
        begin
            width_eff = (CW+1)'(MAX_WIDTH);
        end
        else
        begin
            width_eff = (CW+1)'(frame_width_reg);
        end
        if (frame_height_reg == 11'd0)
        begin
            height_eff = (RW+1)'(1);
        end
        else if (32'(frame_height_reg) > 32'(MAX_HEIGHT))
        begin
            height_eff = (RW+1)'(MAX_HEIGHT);
        end
        else
        begin
            height_eff = (RW+1)'(frame_height_reg);
        end
        if (32'(window_size_reg) > 32'(MAX_WINDOW))
        begin
            win_eff = WNW'(MAX_WINDOW);
        end
        else
        begin
            win_eff = WNW'(window_size_reg);
        end
    end

    assign in_xfer    = in_valid && in_ready;
    assign active_now = (win_eff != '0) && (32'(row_reg) >= 32'(win_eff))
                        && (32'(col_reg) >= 32'(win_eff));
    assign col_inc    = {1'b0, col_reg} + (CW+1)'(1);
    assign row_inc    = {1'b0, row_reg} + (RW+1)'(1);
    assign row_last   = col_inc >= width_eff;
    assign scan_last  = (cnt_i_reg == win_reg - WNW'(1)) && (cnt_j_reg == win_reg - WNW'(1));
    assign load_out   = (state_reg == hwcv_pkg::ST_DECIDE) && (!out_valid_reg || out_ready);

    assign vote  = hwcv_pkg::classify(hue, saturation, brightness, white_high_reg,
                                      white_low_reg, room_enable_reg);
    assign waddr = AW'(slot_reg) * AW'(MAX_WIDTH) + AW'(col_reg);
    assign raddr = AW'(rd_slot_reg) * AW'(MAX_WIDTH) + AW'(rd_col_reg);

    hwcv_ram #(
        .WIDTH (hwcv_pkg::VOTE_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (in_xfer),
        .waddr (waddr),
        .wdata (vote),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            hwcv_pkg::ST_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = active_now ? hwcv_pkg::ST_SCAN : hwcv_pkg::ST_DECIDE;
                end
            end
            hwcv_pkg::ST_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = hwcv_pkg::ST_DRAIN;
                end
            end
            hwcv_pkg::ST_DRAIN:
            begin
                state_next = hwcv_pkg::ST_DECIDE;
            end
            hwcv_pkg::ST_DECIDE:
            begin
                if (load_out)
                begin
                    state_next = hwcv_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = hwcv_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready   = 1'b0;
        ctrl.clear = 1'b0;
        ctrl.add   = rd_pending_reg;
        unique case (state_reg)
            hwcv_pkg::ST_IDLE:
            begin
                in_ready   = 1'b1;
                ctrl.clear = in_valid;
                ctrl.add   = 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= hwcv_pkg::ST_IDLE;
            col_reg        <= '0;
            row_reg        <= '0;
            slot_reg       <= '0;
            rd_pending_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            rd_pending_reg <= (state_reg == hwcv_pkg::ST_SCAN);
            if (in_xfer)
            begin
                if (row_last)
                begin
                    col_reg <= '0;
                    if (row_inc >= height_eff)
                    begin
                        row_reg  <= '0;
                        slot_reg <= '0;
                    end
                    else
                    begin
                        row_reg  <= row_inc[RW-1:0];
                        slot_reg <= (32'(slot_reg) == MAX_WINDOW - 1) ? '0
                                    : slot_reg + SW'(1);
                    end
                end
                else
                begin
                    col_reg <= col_inc[CW-1:0];
                end
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            base_col_reg  <= col_reg;
            rd_col_reg    <= col_reg;
            rd_slot_reg   <= slot_reg;
            cnt_i_reg     <= '0;
            cnt_j_reg     <= '0;
            win_reg       <= win_eff;
            active_reg    <= active_now;
        end
        else if (state_reg == hwcv_pkg::ST_SCAN)
        begin
            if (cnt_j_reg == win_reg - WNW'(1))
            begin
                cnt_j_reg   <= '0;
                cnt_i_reg   <= cnt_i_reg + WNW'(1);
                rd_col_reg  <= base_col_reg;
                rd_slot_reg <= (rd_slot_reg == '0) ? SW'(MAX_WINDOW - 1)
                               : rd_slot_reg - SW'(1);
            end
            else
            begin
                cnt_j_reg  <= cnt_j_reg + WNW'(1);
                rd_col_reg <= rd_col_reg - CW'(1);
            end
        end
        if (load_out)
        begin
            class_reg <= final_class;
            paint_reg <= hwcv_pkg::paint_bgr(final_class);
        end
    end

    assign link_best[0] = '0;
    assign link_idx[0]  = '0;
    assign link_any[0]  = 1'b0;

    for (genvar k = 0; k < NC; k++)
    begin : g_cell
        logic [2:0] amount;
        if (k == NC - 1)
        begin : g_white
            assign amount = rdata[hwcv_pkg::VOTE_W-1:NC-1];
        end
        else
        begin : g_color
            assign amount = {2'b00, rdata[k]};
        end
        hwcv_cell #(
            .SUM_W    (SUM_W),
            .CLASS_ID (3'(k))
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (ctrl),
            .amount   (amount),
            .in_best  (link_best[k]),
            .in_idx   (link_idx[k]),
            .in_any   (link_any[k]),
            .out_best (link_best[k+1]),
            .out_idx  (link_idx[k+1]),
            .out_any  (link_any[k+1])
        );
    end

    assign final_class = (active_reg && link_any[NC]) ? link_idx[NC]
                         : hwcv_pkg::CLASS_UNPAINTED;

    assign out_valid   = out_valid_reg;
    assign class_index = class_reg;
    assign paint_blue  = paint_reg[23:16];
    assign paint_green = paint_reg[15:8];
    assign paint_red   = paint_reg[7:0];

    assign scan_or_drain = (state_reg == hwcv_pkg::ST_SCAN) || (state_reg == hwcv_pkg::ST_DRAIN);
    assign bad_paint     = out_valid_reg && (paint_reg != 24'd0)
                           && (class_reg == hwcv_pkg::CLASS_UNPAINTED
                               || class_reg == hwcv_pkg::CLASS_WHITE);

    `HWCV_ASSERT(a_pending_in_scan, clk, rst_n, rd_pending_reg |-> scan_or_drain, "stray read")
    `HWCV_ASSERT(a_busy_after_xfer, clk, rst_n, in_xfer |=> !in_ready, "idle after a transfer")
    `HWCV_NEVER(a_black_unpainted, clk, rst_n, bad_paint, "paint on an unpainted or white result")

endmodule
